// ===== hdl/panel_cleaner_carriage_sequencer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Panel cleaner carriage sequencer: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef PANEL_CLEANER_CARRIAGE_SEQUENCER_CORE_DEFINES_SVH
`define PANEL_CLEANER_CARRIAGE_SEQUENCER_CORE_DEFINES_SVH

// Checks an implication at every rising edge of clk outside reset.
`define PCS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition never holds at a rising edge of clk outside reset.
`define PCS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// ===== hdl/pcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Panel cleaner carriage sequencer package
// Phase, place and drive codes, register map and configuration defaults.
// ----------------------------------------------------------------------------
package pcs_pkg;

  // Default width and reset value of the pass count register.
  localparam int PASS_BITS_DEF = 8;
  localparam int PASS_RESET    = 4;

  // Register indexes of the configuration port.
  localparam logic REG_PASS_COUNT = 1'b0;

  // Sequencer phases.
  localparam logic [2:0] PH_HOMING = 3'd0;
  localparam logic [2:0] PH_IDLE   = 3'd1;
  localparam logic [2:0] PH_SEEK1  = 3'd2;
  localparam logic [2:0] PH_CLEAN1 = 3'd3;
  localparam logic [2:0] PH_SEEK2  = 3'd4;
  localparam logic [2:0] PH_CLEAN2 = 3'd5;
  localparam logic [2:0] PH_SEEK3  = 3'd6;
  localparam logic [2:0] PH_CLEAN3 = 3'd7;

  // Carriage places.
  localparam logic [2:0] PL_INIT = 3'd0;
  localparam logic [2:0] PL_HOME = 3'd1;
  localparam logic [2:0] PL_ONE  = 3'd2;
  localparam logic [2:0] PL_TWO  = 3'd3;
  localparam logic [2:0] PL_EDGE = 3'd4;

  // Travel motor commands.
  localparam logic [1:0] DR_STOP  = 2'd0;
  localparam logic [1:0] DR_LEFT  = 2'd1;
  localparam logic [1:0] DR_RIGHT = 2'd2;

  // Input command codes.
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Panel selections.
  localparam logic [1:0] PANEL_NONE  = 2'd0;
  localparam logic [1:0] PANEL_ONE   = 2'd1;
  localparam logic [1:0] PANEL_TWO   = 2'd2;
  localparam logic [1:0] PANEL_THREE = 2'd3;

endpackage

// ===== hdl/panel_cleaner_carriage_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// Panel cleaner carriage sequencer core
// Homing, panel seek, brush strokes and return of a cleaning carriage.
// ----------------------------------------------------------------------------
// Each input beat is a sensor sample tick or a start command, and each one
// yields exactly one result beat in the next cycle. The sequencer decides a
// beat in combinational logic from the phase and sensor history registers, so
// a new beat is taken in every cycle that the input is ready, which is whenever
// the result register is empty or its beat is taken in the same cycle. The
// motor, place and busy fields of the result are read straight from the state
// registers, which change only when the next beat is taken. After reset the
// carriage homes; pass_count is written over the APB port at address 0.
`include "panel_cleaner_carriage_sequencer_core_defines.svh"

module panel_cleaner_carriage_sequencer_core
  import pcs_pkg::*;
#(
  parameter int PASS_BITS = PASS_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [1:0]  panel_select,
  input  logic        home_switch,
  input  logic        edge_switch,
  input  logic        prox_level,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  drive,
  output logic        brush_on,
  output logic        water_on,
  output logic [2:0]  place,
  output logic        busy_res,
  output logic        job_done,
  output logic        start_rejected
);

  localparam int CNT_W = PASS_BITS + 1;

  // State registers.
  logic [PASS_BITS-1:0] pass_count;
  logic [2:0]           phase, phase_next;
  logic [CNT_W-1:0]     stroke_count, stroke_count_next;
  logic                 clean_prox_ref, clean_prox_ref_next;
  logic                 seek_prox_ref, seek_prox_ref_next;
  logic [1:0]           seek_edges, seek_edges_next;
  logic                 limit_ref, limit_ref_next;
  logic                 limit_prev, limit_prev_next;
  logic [2:0]           carriage_place, carriage_place_next;
  logic [1:0]           drive_reg, drive_reg_next;
  logic                 brush_reg, brush_reg_next;
  logic                 water_reg, water_reg_next;
  logic                 done_next, rej_next;

  logic             accept;
  logic             prox_fall;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] limit_single;
  logic [CNT_W-1:0] limit_double;
  logic             cfg_write;

  // Configuration port: writes land on the access cycle, reads are direct.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_PASS_COUNT) begin
      prdata = 32'(pass_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_count <= PASS_BITS'(PASS_RESET);
    end else if (cfg_write && paddr[2] == REG_PASS_COUNT) begin
      pass_count <= pwdata[PASS_BITS-1:0];
    end
  end

  // Handshake: the result register parts the two channels.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign prox_fall    = clean_prox_ref && !prox_level;
  assign count_inc    = stroke_count + CNT_W'(1);
  assign limit_single = {1'b0, pass_count};
  assign limit_double = {pass_count, 1'b0};

  // Next state for one beat.
  always_comb begin
    phase_next          = phase;
    stroke_count_next   = stroke_count;
    clean_prox_ref_next = clean_prox_ref;
    seek_prox_ref_next  = seek_prox_ref;
    seek_edges_next     = seek_edges;
    limit_ref_next      = limit_ref;
    limit_prev_next     = limit_prev;
    carriage_place_next = carriage_place;
    drive_reg_next      = drive_reg;
    brush_reg_next      = brush_reg;
    water_reg_next      = water_reg;
    done_next           = 1'b0;
    rej_next            = 1'b0;

    if (cmd == CMD_START) begin
      if (phase != PH_IDLE) begin
        rej_next = 1'b1;
      end else if (panel_select != PANEL_NONE) begin
        // A start takes its own samples as the first references.
        stroke_count_next   = '0;
        seek_edges_next     = 2'd0;
        seek_prox_ref_next  = prox_level;
        clean_prox_ref_next = prox_level;
        limit_prev_next     = 1'b0;
        limit_ref_next      = (panel_select == PANEL_THREE) ? edge_switch : home_switch;
        drive_reg_next      = DR_RIGHT;
        brush_reg_next      = 1'b0;
        water_reg_next      = 1'b0;
        unique case (panel_select)
          PANEL_ONE: phase_next = PH_SEEK1;
          PANEL_TWO: phase_next = PH_SEEK2;
          default:   phase_next = PH_SEEK3;
        endcase
      end
    end else begin
      unique case (phase)
        PH_HOMING: begin
          if (limit_prev && home_switch) begin
            drive_reg_next      = DR_STOP;
            brush_reg_next      = 1'b0;
            water_reg_next      = 1'b0;
            done_next           = (carriage_place != PL_INIT);
            carriage_place_next = PL_HOME;
            phase_next          = PH_IDLE;
            limit_prev_next     = 1'b0;
          end else begin
            drive_reg_next  = DR_LEFT;
            brush_reg_next  = 1'b0;
            water_reg_next  = 1'b0;
            limit_prev_next = home_switch;
          end
        end
        PH_IDLE: begin
        end
        PH_SEEK1: begin
          if (seek_prox_ref && !prox_level) begin
            drive_reg_next      = DR_STOP;
            brush_reg_next      = 1'b0;
            water_reg_next      = 1'b0;
            carriage_place_next = PL_ONE;
            phase_next          = PH_CLEAN1;
          end
          seek_prox_ref_next = prox_level;
        end
        PH_CLEAN1: begin
          // The home switch turns the stroke; marker edges are counted away from it.
          if (home_switch) begin
            if (!limit_ref) begin
              drive_reg_next = DR_RIGHT;
              brush_reg_next = 1'b1;
              water_reg_next = 1'b1;
            end
          end else begin
            if (prox_fall) begin
              stroke_count_next = count_inc;
              drive_reg_next    = DR_LEFT;
              brush_reg_next    = 1'b1;
              water_reg_next    = 1'b1;
              if (count_inc > limit_single) begin
                brush_reg_next  = 1'b0;
                water_reg_next  = 1'b0;
                phase_next      = PH_HOMING;
                limit_prev_next = 1'b0;
              end
            end
            clean_prox_ref_next = prox_level;
          end
          limit_ref_next = home_switch;
        end
        PH_SEEK2: begin
          if (seek_prox_ref && !prox_level) begin
            seek_edges_next = seek_edges + 2'd1;
            if (seek_edges + 2'd1 > 2'd1) begin
              seek_edges_next     = 2'd0;
              drive_reg_next      = DR_STOP;
              brush_reg_next      = 1'b0;
              water_reg_next      = 1'b0;
              carriage_place_next = PL_TWO;
              phase_next          = PH_CLEAN2;
            end
          end
          seek_prox_ref_next = prox_level;
        end
        PH_CLEAN2: begin
          // Every marker edge counts; the stroke direction alternates.
          if (prox_fall) begin
            drive_reg_next    = stroke_count[0] ? DR_RIGHT : DR_LEFT;
            brush_reg_next    = 1'b1;
            water_reg_next    = 1'b0;
            stroke_count_next = count_inc;
            if (count_inc > limit_double) begin
              drive_reg_next  = DR_LEFT;
              brush_reg_next  = 1'b0;
              phase_next      = PH_HOMING;
              limit_prev_next = 1'b0;
            end
          end
          clean_prox_ref_next = prox_level;
        end
        PH_SEEK3: begin
          if (limit_prev && edge_switch) begin
            drive_reg_next      = DR_STOP;
            brush_reg_next      = 1'b0;
            water_reg_next      = 1'b0;
            carriage_place_next = PL_EDGE;
            clean_prox_ref_next = prox_level;
            limit_prev_next     = 1'b0;
            phase_next          = PH_CLEAN3;
          end else begin
            limit_prev_next = edge_switch;
          end
        end
        default: begin
          // Panel three: edge switch rising edges count, marker edges turn right.
          if (edge_switch) begin
            if (!limit_ref) begin
              stroke_count_next = count_inc;
              drive_reg_next    = DR_LEFT;
              brush_reg_next    = 1'b1;
              water_reg_next    = 1'b0;
              if (count_inc > limit_single) begin
                brush_reg_next  = 1'b0;
                phase_next      = PH_HOMING;
                limit_prev_next = 1'b0;
              end
            end
          end else begin
            if (prox_fall) begin
              drive_reg_next = DR_RIGHT;
              brush_reg_next = 1'b1;
              water_reg_next = 1'b0;
            end
            clean_prox_ref_next = prox_level;
          end
          limit_ref_next = edge_switch;
        end
      endcase
    end
  end

  // State update on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HOMING;
      stroke_count   <= '0;
      clean_prox_ref <= 1'b0;
      seek_prox_ref  <= 1'b0;
      seek_edges     <= 2'd0;
      limit_ref      <= 1'b0;
      limit_prev     <= 1'b0;
      carriage_place <= PL_INIT;
      drive_reg      <= DR_STOP;
      brush_reg      <= 1'b0;
      water_reg      <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      stroke_count   <= stroke_count_next;
      clean_prox_ref <= clean_prox_ref_next;
      seek_prox_ref  <= seek_prox_ref_next;
      seek_edges     <= seek_edges_next;
      limit_ref      <= limit_ref_next;
      limit_prev     <= limit_prev_next;
      carriage_place <= carriage_place_next;
      drive_reg      <= drive_reg_next;
      brush_reg      <= brush_reg_next;
      water_reg      <= water_reg_next;
    end
  end

  // Result register: valid flag and the per-beat pulses.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_done       <= done_next;
      start_rejected <= rej_next;
    end
  end

  // The held result fields come from the state that this beat left.
  assign drive    = drive_reg;
  assign brush_on = brush_reg;
  assign water_on = water_reg;
  assign place    = carriage_place;
  assign busy_res = (phase != PH_IDLE);

  // A new beat is taken over a waiting result only when that result leaves.
  `PCS_ASSERT_IMPL(a_no_overwrite, accept && out_valid, out_ready,
                   "result overwritten before it was taken")
  // A finished job always reports from home and idle.
  `PCS_ASSERT_IMPL(a_done_at_home, out_valid && job_done,
                   place == PL_HOME && !busy_res, "job done away from home")
  // A beat is either a rejected start or a tick; never both outcomes.
  `PCS_ASSERT_NEVER(a_done_rej, out_valid && job_done && start_rejected,
                    "job done and start rejected on one beat")
  // Water runs only during panel-one strokes.
  `PCS_ASSERT_IMPL(a_water_panel_one, water_reg, phase == PH_CLEAN1 && brush_reg,
                   "water on outside panel-one cleaning")

endmodule

// ===== sim/tb_panel_cleaner_carriage_sequencer_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Panel cleaner carriage sequencer core testbench
// Drives sensor ticks and start commands with random gaps and stalls on both
// sides. Every accepted input beat is run through a behavioral predictor of
// the carriage sequencer, and each result beat is compared field by field.
// ----------------------------------------------------------------------------
module tb_panel_cleaner_carriage_sequencer_core;
  import pcs_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int LONG_HOLD   = 150;

  // One input beat.
  typedef struct packed {
    logic       cmd;
    logic [1:0] panel;
    logic       home_sw;
    logic       edge_sw;
    logic       prox;
  } sensor_beat_t;

  // One result beat.
  typedef struct packed {
    logic [1:0] drive;
    logic       brush;
    logic       water;
    logic [2:0] place;
    logic       busy;
    logic       done;
    logic       rejected;
  } carriage_status_t;

  // Sequencer state as the predictor tracks it.
  typedef struct packed {
    logic [2:0] phase;
    logic [1:0] panel;
    logic [8:0] strokes;
    logic       clean_ref;
    logic       seek_ref;
    logic [1:0] seek_edges;
    logic       limit_ref;
    logic       limit_prev;
    logic [2:0] place;
    logic [1:0] drive;
    logic       brush;
    logic       water;
  } carriage_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = CMD_TICK;
  logic [1:0]  panel_select = PANEL_NONE;
  logic        home_switch = 1'b0;
  logic        edge_switch = 1'b0;
  logic        prox_level = 1'b1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  drive;
  logic        brush_on;
  logic        water_on;
  logic [2:0]  place;
  logic        busy_res;
  logic        job_done;
  logic        start_rejected;

  sensor_beat_t     pending_items[$];
  carriage_status_t expected_status[$];

  carriage_state_t model_state;
  carriage_state_t plan_state;
  logic [7:0]      model_passes = 8'(PASS_RESET);
  logic [7:0]      plan_passes = 8'(PASS_RESET);
  int              error_count = 0;
  int              stuck_cycles = 0;
  int              hold_requests = 0;
  bit              in_taken = 1'b0;

  panel_cleaner_carriage_sequencer_core dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .panel_select   (panel_select),
    .home_switch    (home_switch),
    .edge_switch    (edge_switch),
    .prox_level     (prox_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .drive          (drive),
    .brush_on       (brush_on),
    .water_on       (water_on),
    .place          (place),
    .busy_res       (busy_res),
    .job_done       (job_done),
    .start_rejected (start_rejected)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // State right after reset: homing from an unknown place, motors off.
  function automatic carriage_state_t reset_carriage();
    carriage_state_t st;
    st = '0;
    st.phase = PH_HOMING;
    st.place = PL_INIT;
    st.drive = DR_STOP;
    return st;
  endfunction

  function automatic void set_motors(inout carriage_state_t st, input logic [1:0] d,
                                     input logic b, input logic w);
    st.drive = d;
    st.brush = b;
    st.water = w;
  endfunction

  // The final counted event stops the brush and sends the carriage home.
  function automatic void head_home(inout carriage_state_t st);
    set_motors(st, DR_LEFT, 1'b0, 1'b0);
    st.phase = PH_HOMING;
    st.limit_prev = 1'b0;
  endfunction

  // Advances the sequencer by one beat and returns the result it produces.
  function automatic carriage_status_t advance_carriage(inout carriage_state_t st,
                                                        input sensor_beat_t b,
                                                        input logic [7:0] passes);
    carriage_status_t r;
    r = '0;
    if (b.cmd == CMD_START) begin
      if (st.phase != PH_IDLE) begin
        r.rejected = 1'b1;
      end else if (b.panel != PANEL_NONE) begin
        st.panel = b.panel;
        st.strokes = '0;
        st.seek_edges = '0;
        st.seek_ref = b.prox;
        st.clean_ref = b.prox;
        st.limit_prev = 1'b0;
        st.limit_ref = (b.panel == PANEL_THREE) ? b.edge_sw : b.home_sw;
        set_motors(st, DR_RIGHT, 1'b0, 1'b0);
        st.phase = (b.panel == PANEL_ONE) ? PH_SEEK1 :
                   (b.panel == PANEL_TWO) ? PH_SEEK2 : PH_SEEK3;
      end
    end else begin
      case (st.phase)
        PH_HOMING: begin
          // Home needs the switch pressed on two ticks in a row.
          if (st.limit_prev && b.home_sw) begin
            set_motors(st, DR_STOP, 1'b0, 1'b0);
            r.done = (st.place != PL_INIT);
            st.place = PL_HOME;
            st.phase = PH_IDLE;
            st.limit_prev = 1'b0;
          end else begin
            set_motors(st, DR_LEFT, 1'b0, 1'b0);
            st.limit_prev = b.home_sw;
          end
        end
        PH_SEEK1: begin
          if (st.seek_ref && !b.prox) begin
            set_motors(st, DR_STOP, 1'b0, 1'b0);
            st.place = PL_ONE;
            st.phase = PH_CLEAN1;
          end
          st.seek_ref = b.prox;
        end
        PH_CLEAN1: begin
          // A rising home switch turns the stroke around; marker edges count.
          if (b.home_sw) begin
            if (!st.limit_ref) set_motors(st, DR_RIGHT, 1'b1, 1'b1);
          end else begin
            if (st.clean_ref && !b.prox) begin
              st.strokes = st.strokes + 9'd1;
              set_motors(st, DR_LEFT, 1'b1, 1'b1);
              if (st.strokes > {1'b0, passes}) head_home(st);
            end
            st.clean_ref = b.prox;
          end
          st.limit_ref = b.home_sw;
        end
        PH_SEEK2: begin
          // Panel two sits at the second marker.
          if (st.seek_ref && !b.prox) begin
            st.seek_edges = st.seek_edges + 2'd1;
            if (st.seek_edges > 2'd1) begin
              st.seek_edges = '0;
              set_motors(st, DR_STOP, 1'b0, 1'b0);
              st.place = PL_TWO;
              st.phase = PH_CLEAN2;
            end
          end
          st.seek_ref = b.prox;
        end
        PH_CLEAN2: begin
          // Every marker edge counts, and the stroke direction alternates.
          if (st.clean_ref && !b.prox) begin
            if (!st.strokes[0]) set_motors(st, DR_LEFT, 1'b1, 1'b0);
            else set_motors(st, DR_RIGHT, 1'b1, 1'b0);
            st.strokes = st.strokes + 9'd1;
            if (st.strokes > {passes, 1'b0}) head_home(st);
          end
          st.clean_ref = b.prox;
        end
        PH_SEEK3: begin
          if (st.limit_prev && b.edge_sw) begin
            set_motors(st, DR_STOP, 1'b0, 1'b0);
            st.place = PL_EDGE;
            st.clean_ref = b.prox;
            st.limit_prev = 1'b0;
            st.phase = PH_CLEAN3;
          end else begin
            st.limit_prev = b.edge_sw;
          end
        end
        PH_CLEAN3: begin
          // Edge switch rises are counted; a marker edge sends it right again.
          if (b.edge_sw) begin
            if (!st.limit_ref) begin
              st.strokes = st.strokes + 9'd1;
              set_motors(st, DR_LEFT, 1'b1, 1'b0);
              if (st.strokes > {1'b0, passes}) head_home(st);
            end
          end else begin
            if (st.clean_ref && !b.prox) set_motors(st, DR_RIGHT, 1'b1, 1'b0);
            st.clean_ref = b.prox;
          end
          st.limit_ref = b.edge_sw;
        end
        default: begin
        end
      endcase
    end
    r.drive = st.drive;
    r.brush = st.brush;
    r.water = st.water;
    r.place = st.place;
    r.busy = (st.phase != PH_IDLE);
    return r;
  endfunction

  // Picks sensor samples that a real carriage would plausibly report in the
  // current phase, with some fully random beats mixed in.
  function automatic sensor_beat_t plan_beat(input carriage_state_t st);
    sensor_beat_t b;
    b.cmd = CMD_TICK;
    b.panel = 2'($urandom_range(0, 3));
    b.home_sw = 1'($urandom_range(0, 1));
    b.edge_sw = 1'($urandom_range(0, 1));
    b.prox = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 15) begin
      b.cmd = 1'($urandom_range(0, 1));
      return b;
    end
    case (st.phase) inside
      PH_HOMING: b.home_sw = ($urandom_range(0, 9) < 6);
      PH_IDLE:   b.cmd = $urandom_range(0, 1) ? CMD_START : CMD_TICK;
      PH_SEEK1, PH_SEEK2: b.prox = ($urandom_range(0, 4) != 0) ? !st.seek_ref : st.seek_ref;
      PH_CLEAN1: begin
        b.home_sw = ($urandom_range(0, 9) == 0);
        b.prox = ($urandom_range(0, 4) != 0) ? !st.clean_ref : st.clean_ref;
      end
      PH_CLEAN2: b.prox = ($urandom_range(0, 4) != 0) ? !st.clean_ref : st.clean_ref;
      PH_SEEK3:  b.edge_sw = ($urandom_range(0, 9) < 6);
      PH_CLEAN3: b.edge_sw = ($urandom_range(0, 4) != 0) ? !st.limit_ref : st.limit_ref;
      default: begin
      end
    endcase
    return b;
  endfunction

  // Gap length for either side: mostly none, some short, a few long, with
  // occasional quiet stretches of back-to-back beats.
  function automatic int pick_gap(inout int quiet);
    int roll;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic sensor_beat_t make_beat(input logic c, input logic [1:0] sel,
                                             input logic h, input logic e, input logic p);
    sensor_beat_t b;
    b.cmd = c;
    b.panel = sel;
    b.home_sw = h;
    b.edge_sw = e;
    b.prox = p;
    return b;
  endfunction

  // Queues a beat for the driver and keeps the stimulus planner in step.
  task automatic queue_beat(input sensor_beat_t b);
    void'(advance_carriage(plan_state, b, plan_passes));
    pending_items.push_back(b);
  endtask

  task automatic write_pass_count(input logic [7:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_PASS_COUNT, 2'b00};
    pwdata <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    model_passes = value;
    plan_passes = value;
  endtask

  // Waits until every queued beat has been taken and every result has come.
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_status.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic check_field(input string label, input logic [2:0] want,
                             input logic [2:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
      error_count++;
    end
  endtask

  // Driver: presents the next pending beat once the current one is taken.
  int send_gap = 0;
  int send_quiet = 0;
  always @(negedge clk) begin
    sensor_beat_t next_beat;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap == 0 && pending_items.size() != 0) begin
        next_beat = pending_items.pop_front();
        cmd <= next_beat.cmd;
        panel_select <= next_beat.panel;
        home_switch <= next_beat.home_sw;
        edge_switch <= next_beat.edge_sw;
        prox_level <= next_beat.prox;
        in_valid <= 1'b1;
        send_gap = pick_gap(send_quiet);
      end else begin
        in_valid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  int recv_stall = 0;
  int recv_quiet = 0;
  int holds_served = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (holds_served != hold_requests) begin
        holds_served++;
        recv_stall = LONG_HOLD;
      end
      if (recv_stall > 0) begin
        out_ready <= 1'b0;
        recv_stall--;
      end else begin
        recv_stall = pick_gap(recv_quiet);
        out_ready <= (recv_stall == 0);
        if (recv_stall > 0) recv_stall--;
      end
    end
  end

  // Monitor: predicts each accepted input beat, checks each result beat, and
  // ends the run if nothing moves for too long.
  always @(posedge clk) begin
    carriage_status_t want;
    in_taken = !rst && in_valid && in_ready;
    if (in_taken) begin
      expected_status.push_back(advance_carriage(model_state,
          make_beat(cmd, panel_select, home_switch, edge_switch, prox_level), model_passes));
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        $display("%0t ns: result beat arrived with nothing expected", $time);
        error_count++;
      end else begin
        want = expected_status.pop_front();
        check_field("drive", 3'(want.drive), 3'(drive));
        check_field("brush_on", 3'(want.brush), 3'(brush_on));
        check_field("water_on", 3'(want.water), 3'(water_on));
        check_field("place", want.place, place);
        check_field("busy_res", 3'(want.busy), 3'(busy_res));
        check_field("job_done", 3'(want.done), 3'(job_done));
        check_field("start_rejected", 3'(want.rejected), 3'(start_rejected));
      end
    end
    if (in_taken || (out_valid && out_ready) || (psel && penable && pwrite)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t ns: no beat moved for %0d cycles", $time, STUCK_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Stimulus: a directed opening, then random phases at several pass counts.
  initial begin
    logic [7:0] pass_plan [5];
    model_state = reset_carriage();
    plan_state = reset_carriage();
    pass_plan = '{8'd0, 8'd255, 8'd1, 8'd3, 8'd0};
    pass_plan[3] = 8'($urandom_range(2, 6));

    // Power-up homing, with a start refused while homing.
    queue_beat(make_beat(CMD_TICK, PANEL_NONE, 1'b1, 1'b0, 1'b1));
    queue_beat(make_beat(CMD_START, PANEL_ONE, 1'b1, 1'b1, 1'b0));
    queue_beat(make_beat(CMD_TICK, PANEL_NONE, 1'b0, 1'b1, 1'b0));
    queue_beat(make_beat(CMD_TICK, PANEL_TWO, 1'b1, 1'b0, 1'b1));
    queue_beat(make_beat(CMD_TICK, PANEL_NONE, 1'b1, 1'b0, 1'b1));
    // Idle at home: a start for no panel is ignored, ticks change nothing.
    queue_beat(make_beat(CMD_START, PANEL_NONE, 1'b1, 1'b1, 1'b1));
    queue_beat(make_beat(CMD_TICK, PANEL_THREE, 1'b1, 1'b1, 1'b1));
    // Panel one job; the start beat's own marker sample is the seek reference.
    queue_beat(make_beat(CMD_START, PANEL_ONE, 1'b0, 1'b0, 1'b1));
    queue_beat(make_beat(CMD_START, PANEL_TWO, 1'b0, 1'b1, 1'b0));
    queue_beat(make_beat(CMD_TICK, PANEL_NONE, 1'b0, 1'b0, 1'b0));
    queue_beat(make_beat(CMD_TICK, PANEL_NONE, 1'b1, 1'b0, 1'b0));
    queue_beat(make_beat(CMD_TICK, PANEL_NONE, 1'b0, 1'b1, 1'b1));
    queue_beat(make_beat(CMD_TICK, PANEL_NONE, 1'b0, 1'b0, 1'b0));
    // The job carries on with random beats at the reset pass count.
    for (int i = 0; i < 120; i++) queue_beat(plan_beat(plan_state));

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      write_pass_count(pass_plan[p]);
      for (int i = 0; i < 150; i++) queue_beat(plan_beat(plan_state));
      if (p == 0) hold_requests++;
      wait_idle();
    end

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/pcs_pkg.sv
hdl/panel_cleaner_carriage_sequencer_core.sv
sim/tb_panel_cleaner_carriage_sequencer_core.sv
